@@ rtl/dbd_pkg.sv @@
// dbd_pkg: widths, calendar constants and the month table for days_between_dates_core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned COUNT_W = 18;
	// day numbers run from -1 (day 0 of the first month) to about 194k
	localparam int unsigned DNUM_W  = COUNT_W + 1;
	localparam int unsigned DIFF_W  = DNUM_W + 1;
	localparam int unsigned YOFF_W  = 10;

	localparam logic [YEAR_W-1:0]  YEAR_FIRST = 12'd1971;
	localparam logic [YEAR_W-1:0]  YEAR_LAST  = 12'd2500;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DNUM_W-1:0]  DAYS_COMMON_YEAR = 19'd365;

	typedef logic signed [DNUM_W-1:0] dnum_t;

	// days in a common year before the first of the given month
	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [8:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/dbd_day_num.sv @@
// dbd_day_num: maps a date to its day number counted from 1971-01-01 (day 0)
// depends on dbd_pkg; combinational, one per date in the core
`timescale 1ns / 1ps

module dbd_day_num import dbd_pkg::*; (
	input  logic [DAY_W-1:0]   day,
	input  logic [MONTH_W-1:0] month,
	input  logic [YEAR_W-1:0]  year,
	output dnum_t              dnum
);

	logic [YEAR_W-1:0]  year_c;
	logic [MONTH_W-1:0] month_c;
	logic [YOFF_W-1:0]  yoff;
	logic [8:0]         leap_days;
	logic               leap_adj;
	logic [DNUM_W-1:0]  sum;

	always_comb begin
		if (year < YEAR_FIRST) begin
			year_c = YEAR_FIRST;
		end else if (year > YEAR_LAST) begin
			year_c = YEAR_LAST;
		end else begin
			year_c = year;
		end

		if (month < MONTH_JAN) begin
			month_c = MONTH_JAN;
		end else if (month > MONTH_DEC) begin
			month_c = MONTH_DEC;
		end else begin
			month_c = month;
		end

		yoff = YOFF_W'(year_c - YEAR_FIRST);
		// leap days in the years before this one: floor((yoff + 2) / 4)
		leap_days = 9'((11'(yoff) + 11'd2) >> 2);
		// year divisible by 4 exactly when yoff mod 4 is 1
		leap_adj = (yoff[1:0] == 2'd1) && (month_c > MONTH_FEB);

		sum = DNUM_W'(yoff) * DAYS_COMMON_YEAR + DNUM_W'(leap_days)
			+ DNUM_W'(days_before_month(month_c)) + DNUM_W'(leap_adj) + DNUM_W'(day);
		dnum = $signed(sum - DNUM_W'(1));
	end

endmodule

@@ rtl/days_between_dates_core.sv @@
// days_between_dates_core: number of days from a begin date to an end date
// depends on dbd_pkg and dbd_day_num
`timescale 1ns / 1ps
//
// usage:
//   drive the six date fields and raise start; the item is taken at the rising
//   edge where start is high and busy is low. busy is never raised, so a new
//   item can be taken at every clock edge.
//   years are clamped to 1971..2500 and months to 1..12; days are not checked
//   against month length. leap years are all years divisible by 4.
//   each item gives one result via the input and result registers: done is high for
//   exactly one cycle with order_status and day_count valid in that cycle.
//   order_status is 1 (and day_count 0) when the end date is not strictly later.
// pipeline: input register, then day numbers and subtract into the result
//   register; throughput: one item per cycle.
// reset: arst_n low clears the valid flags of both stages; no result is lost
//   to a stall since the receiver cannot hold results off.
//
module days_between_dates_core import dbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [DAY_W-1:0]   begin_day,
	input  logic [MONTH_W-1:0] begin_month,
	input  logic [YEAR_W-1:0]  begin_year,
	input  logic [DAY_W-1:0]   end_day,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [YEAR_W-1:0]  end_year,
	output logic               done,
	output logic               order_status,
	output logic [COUNT_W-1:0] day_count
);

	logic               vld_s1;
	logic [DAY_W-1:0]   bday_s1, eday_s1;
	logic [MONTH_W-1:0] bmon_s1, emon_s1;
	logic [YEAR_W-1:0]  byr_s1, eyr_s1;

	dnum_t              bnum, enum_v;
	logic signed [DIFF_W-1:0] diff;
	logic               not_later;

	logic               vld_s2;
	logic               status_s2;
	logic [COUNT_W-1:0] count_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			bday_s1 <= begin_day;
			bmon_s1 <= begin_month;
			byr_s1  <= begin_year;
			eday_s1 <= end_day;
			emon_s1 <= end_month;
			eyr_s1  <= end_year;
		end
	end

	dbd_day_num u_begin (
		.day   (bday_s1),
		.month (bmon_s1),
		.year  (byr_s1),
		.dnum  (bnum)
	);

	dbd_day_num u_end (
		.day   (eday_s1),
		.month (emon_s1),
		.year  (eyr_s1),
		.dnum  (enum_v)
	);

	always_comb begin
		diff      = DIFF_W'(enum_v) - DIFF_W'(bnum);
		not_later = (diff <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_s2 <= not_later;
			count_s2  <= not_later ? '0 : diff[COUNT_W-1:0];
		end
	end

	assign done         = vld_s2;
	assign order_status = status_s2;
	assign day_count    = count_s2;

endmodule

@@ rtl/dbd_checker.sv @@
// dbd_checker: port-level checks for days_between_dates_core, bound to the top level
// depends on dbd_pkg
`timescale 1ns / 1ps

module dbd_checker import dbd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               order_status,
	input logic [COUNT_W-1:0] day_count
);

	// every taken item gives its result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("taken item gave no result");

	// no result without a taken item
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an item");

	a_zero_when_not_later: assert property (@(posedge clk) disable iff (!arst_n)
		done && order_status |-> day_count == '0)
		else $error("day count not zero for end not later");

	a_nonzero_when_later: assert property (@(posedge clk) disable iff (!arst_n)
		done && !order_status |-> day_count != '0)
		else $error("zero day count for a later end date");

endmodule

bind days_between_dates_core dbd_checker u_dbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.order_status (order_status),
	.day_count    (day_count)
);

@@ tb/testbench.sv @@
// testbench: self-checking bench for days_between_dates_core, directed table then random date pairs
// depends on dbd_pkg and the days_between_dates_core rtl; predicts untyped items by its own calendar math
`timescale 1ns / 1ps

module testbench;
	import dbd_pkg::*;

	localparam int N_RANDOM   = 1500;
	localparam int IDLE_LIMIT = 500;
	localparam int DRAIN_WAIT = 4;
	localparam int PAUSE_AT   = 700;
	localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	typedef struct {
		logic [DAY_W-1:0]   bd;
		logic [MONTH_W-1:0] bm;
		logic [YEAR_W-1:0]  by;
		logic [DAY_W-1:0]   ed;
		logic [MONTH_W-1:0] em;
		logic [YEAR_W-1:0]  ey;
		bit                 typed;
		bit                 exp_status;
		int                 exp_count;
	} date_pair_t;

	typedef struct {
		bit status;
		int count;
	} span_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               done;
	logic               order_status;
	logic [COUNT_W-1:0] day_count;

	date_pair_t cur = '{default: '0};
	span_t      span_q[$];
	date_pair_t directed_rows[];
	int         error_count = 0;
	int         items_sent = 0;
	int         results_seen = 0;
	int         late_seen = 0;
	int         idle_cycles = 0;

	always #10 clk = ~clk;

	days_between_dates_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.begin_day    (cur.bd),
		.begin_month  (cur.bm),
		.begin_year   (cur.by),
		.end_day      (cur.ed),
		.end_month    (cur.em),
		.end_year     (cur.ey),
		.done         (done),
		.order_status (order_status),
		.day_count    (day_count)
	);

	// days since the first of january of the first year, with clamped year and month
	function automatic int day_index(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
			logic [YEAR_W-1:0] y);
		int yy;
		int mm;
		int n;
		yy = int'(y);
		if (yy < int'(YEAR_FIRST)) yy = int'(YEAR_FIRST);
		if (yy > int'(YEAR_LAST)) yy = int'(YEAR_LAST);
		mm = int'(m);
		if (mm < 1) mm = 1;
		if (mm > 12) mm = 12;
		n = (yy - int'(YEAR_FIRST)) * 365 + (yy - 1) / 4 - (int'(YEAR_FIRST) - 1) / 4;
		n += MONTH_START[mm-1];
		if ((yy % 4) == 0 && mm > 2) n += 1;
		n += int'(d) - 1;
		return n;
	endfunction

	function automatic span_t predict_span(date_pair_t p);
		span_t s;
		int diff;
		diff = day_index(p.ed, p.em, p.ey) - day_index(p.bd, p.bm, p.by);
		if (diff <= 0) begin
			s.status = 1'b1;
			s.count = 0;
		end else begin
			s.status = 1'b0;
			s.count = diff;
		end
		return s;
	endfunction

	function automatic date_pair_t mk_row(int bd, int bm, int by, int ed, int em, int ey,
			int typed, int st, int cnt);
		date_pair_t p;
		p.bd = DAY_W'(bd);
		p.bm = MONTH_W'(bm);
		p.by = YEAR_W'(by);
		p.ed = DAY_W'(ed);
		p.em = MONTH_W'(em);
		p.ey = YEAR_W'(ey);
		p.typed = (typed != 0);
		p.exp_status = (st != 0);
		p.exp_count = cnt;
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// record the expectation for every item taken
	always @(posedge clk) begin
		span_t s;
		if (arst_n && start && !busy) begin
			if (cur.typed) begin
				s.status = cur.exp_status;
				s.count = cur.exp_count;
			end else begin
				s = predict_span(cur);
			end
			span_q.push_back(s);
		end
	end

	always @(posedge clk) begin
		span_t s;
		if (arst_n && done) begin
			results_seen++;
			if (order_status) late_seen++;
			if (span_q.size() == 0) begin
				report_mismatch("result with nothing pending", int'(day_count), -1);
			end else begin
				s = span_q.pop_front();
				if (order_status !== s.status)
					report_mismatch("order_status", int'(order_status), int'(s.status));
				if (day_count !== s.count[COUNT_W-1:0])
					report_mismatch("day_count", int'(day_count), s.count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("watchdog: no item or result for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic drive_item(date_pair_t p, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cur <= p;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	function automatic date_pair_t random_pair();
		date_pair_t p;
		p.typed = 1'b0;
		p.exp_status = 1'b0;
		p.exp_count = 0;
		case ($urandom_range(0, 9))
			0, 1: begin
				// raw bits, out of range values included
				p.bd = DAY_W'($urandom_range(0, 31));
				p.bm = MONTH_W'($urandom_range(0, 15));
				p.by = YEAR_W'($urandom_range(0, 4095));
				p.ed = DAY_W'($urandom_range(0, 31));
				p.em = MONTH_W'($urandom_range(0, 15));
				p.ey = YEAR_W'($urandom_range(0, 4095));
			end
			2, 3, 4: begin
				// close pair: end differs from begin by at most one in one field
				p.bd = DAY_W'($urandom_range(1, 30));
				p.bm = MONTH_W'($urandom_range(2, 11));
				p.by = YEAR_W'($urandom_range(1972, 2499));
				p.ed = p.bd;
				p.em = p.bm;
				p.ey = p.by;
				case ($urandom_range(0, 2))
					0: p.ed = DAY_W'(int'(p.bd) + int'($urandom_range(0, 2)) - 1);
					1: p.em = MONTH_W'(int'(p.bm) + int'($urandom_range(0, 2)) - 1);
					default: p.ey = YEAR_W'(int'(p.by) + int'($urandom_range(0, 2)) - 1);
				endcase
			end
			default: begin
				p.bd = DAY_W'($urandom_range(1, 31));
				p.bm = MONTH_W'($urandom_range(1, 12));
				p.by = YEAR_W'($urandom_range(int'(YEAR_FIRST), int'(YEAR_LAST)));
				p.ed = DAY_W'($urandom_range(1, 31));
				p.em = MONTH_W'($urandom_range(1, 12));
				p.ey = YEAR_W'($urandom_range(int'(YEAR_FIRST), int'(YEAR_LAST)));
			end
		endcase
		return p;
	endfunction

	initial begin
		int gap;
		directed_rows = '{
			mk_row(1, 1, 1971, 1, 1, 1971, 1, 1, 0),
			mk_row(1, 1, 1971, 2, 1, 1971, 1, 0, 1),
			mk_row(1, 1, 1971, 31, 12, 2500, 1, 0, 193582),
			mk_row(31, 12, 2500, 1, 1, 1971, 1, 1, 0),
			mk_row(0, 0, 0, 1, 1, 1971, 1, 0, 1),
			mk_row(31, 15, 4095, 31, 12, 2500, 1, 1, 0),
			mk_row(1, 1, 0, 31, 15, 4095, 1, 0, 193582),
			// february 31 sorts after march 1
			mk_row(31, 2, 1972, 1, 3, 1972, 1, 1, 0),
			mk_row(28, 2, 1972, 1, 3, 1972, 0, 0, 0),
			mk_row(28, 2, 1973, 1, 3, 1973, 0, 0, 0),
			mk_row(31, 12, 1971, 1, 1, 1972, 1, 0, 1),
			mk_row(1, 13, 2000, 1, 12, 2000, 1, 1, 0),
			mk_row(0, 5, 2100, 31, 5, 2100, 0, 0, 0),
			mk_row(15, 6, 1999, 14, 6, 1999, 1, 1, 0),
			mk_row(1, 1, 2499, 1, 1, 2500, 0, 0, 0),
			mk_row(29, 2, 2400, 1, 3, 2400, 0, 0, 0),
			mk_row(1, 3, 1971, 1, 3, 2100, 0, 0, 0)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i], $urandom_range(0, 10));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == PAUSE_AT) begin
				// hold off until the pipeline has drained
				start <= 1'b0;
				@(posedge clk);
				while (span_q.size() != 0) @(posedge clk);
			end
			// alternate stretches of back-to-back items with randomly gapped ones
			gap = ((i / 100) % 2 == 1) ? 0 : $urandom_range(0, 10);
			drive_item(random_pair(), gap);
		end
		start <= 1'b0;

		while (span_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d date pairs (%0d directed), checked %0d results, %0d not later",
			items_sent, directed_rows.size(), results_seen, late_seen);
		$display("mismatches: %0d", error_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
